/* sv/cmvt_pkg.sv */
// shared types, constants and helpers for the complex matrix-vector transform unit
// no dependencies; imported by every module of the block
package cmvt_pkg;

  // fixed field widths
  localparam int ACC_W       = 40;
  localparam int LEN_W       = 7;
  localparam int OUT_ROW_W   = 6;
  localparam int ADDR_W      = 12;
  localparam int STORE_DEPTH = 4096;
  localparam int CFG_IDX_W   = 1;

  // request opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_VECTOR = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LENGTH = 1'b1;

  // complex accumulator value
  typedef struct packed {
    logic signed [ACC_W-1:0] re;
    logic signed [ACC_W-1:0] im;
  } acc_t;

  // control shared by every cell of the accumulator chain
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] v, int maxv);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (int'(v) > maxv) begin
      r = LEN_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* sv/cmvt_coef_mem.sv */
// coefficient store: one write port, one registered read port
// depends on cmvt_pkg for the store depth and address width
module cmvt_coef_mem
  import cmvt_pkg::*;
#(
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [STORE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/cmvt_mac.sv */
// complex multiply pipeline: registered partial products, then registered sums
// depends on cmvt_pkg for the accumulator type
module cmvt_mac
  import cmvt_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_vld,
  input  logic                         in_active,
  input  logic signed [DATA_WIDTH-1:0] coef_re,
  input  logic signed [DATA_WIDTH-1:0] coef_im,
  input  logic signed [DATA_WIDTH-1:0] x_re,
  input  logic signed [DATA_WIDTH-1:0] x_im,
  output logic                         busy,
  output logic                         sum_vld,
  output acc_t                         sum
);

  localparam int PROD_W = 2 * DATA_WIDTH;

  logic                     prod_vld;
  logic                     prod_active;
  logic signed [PROD_W-1:0] p_rr;
  logic signed [PROD_W-1:0] p_ii;
  logic signed [PROD_W-1:0] p_ri;
  logic signed [PROD_W-1:0] p_ir;

  // control of both stages
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      sum_vld  <= 1'b0;
    end else begin
      prod_vld <= in_vld;
      sum_vld  <= prod_vld;
    end
  end

  // four partial products
  always_ff @(posedge clk) begin
    prod_active <= in_active;
    p_rr        <= coef_re * x_re;
    p_ii        <= coef_im * x_im;
    p_ri        <= coef_re * x_im;
    p_ir        <= coef_im * x_re;
  end

  // complex sum, wrapped to accumulator width; inactive rows add nothing
  always_ff @(posedge clk) begin
    if (prod_active) begin
      sum.re <= ACC_W'(p_rr) - ACC_W'(p_ii);
      sum.im <= ACC_W'(p_ri) + ACC_W'(p_ir);
    end else begin
      sum.re <= '0;
      sum.im <= '0;
    end
  end

  assign busy = prod_vld | sum_vld;

endmodule

/* sv/cmvt_cell.sv */
// one accumulator cell of the rotating chain
// depends on cmvt_pkg for the accumulator and control types
module cmvt_cell
  import cmvt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  acc_t       prev,
  input  acc_t       addend,
  output acc_t       value
);

  // take the neighbor's value plus addend on shift, zero on reset or clear
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      value <= '0;
    end else if (ctrl.shift) begin
      value.re <= prev.re + addend.re;
      value.im <= prev.im + addend.im;
    end
  end

endmodule

/* sv/complex_matrix_vector_transform_unit.sv */
// top level: request sequencer, coefficient store, multiply pipeline, accumulator chain
// depends on cmvt_pkg, cmvt_coef_mem, cmvt_mac and cmvt_cell
//
// Computes y = A'x over complex Q1.15 data with 40-bit Q10.30 accumulators. A load request
// (op 0) writes one coefficient at coef_index. A vector request (op 1) streams all
// MAX_OUT_LEN coefficients of its column from the store, one per cycle, through a
// four-multiplier pipeline into a ring of MAX_OUT_LEN accumulator cells that rotates by one
// each time a product arrives. When in_length elements are in, out_length results follow,
// rows 0 upward with is_last on the final one, one per accepted output cycle, and the
// accumulators clear. in_length and out_length read 0 as 1 and saturate at the maximum.
// Configuration writes are taken at any time but belong in idle periods.
module complex_matrix_vector_transform_unit
  import cmvt_pkg::*;
#(
  parameter int MAX_IN_LEN  = 64,
  parameter int MAX_OUT_LEN = 64,
  parameter int DATA_WIDTH  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         op,
  input  logic [ADDR_W-1:0]            coef_index,
  input  logic signed [DATA_WIDTH-1:0] in_real,
  input  logic signed [DATA_WIDTH-1:0] in_imag,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [OUT_ROW_W-1:0]         out_row,
  output logic signed [ACC_W-1:0]      out_real,
  output logic signed [ACC_W-1:0]      out_imag,
  output logic                         is_last,
  // configuration channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [LEN_W-1:0]             cfg_data
);

  localparam int ROW_W = $clog2(MAX_OUT_LEN + 1);
  localparam int CNT_W = $clog2(MAX_IN_LEN + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t                  state;
  logic [LEN_W-1:0]        in_len;
  logic [LEN_W-1:0]        out_len;
  logic [LEN_W-1:0]        lx;
  logic [LEN_W-1:0]        ly;
  logic [CNT_W-1:0]        count;
  logic [ROW_W-1:0]        row;
  logic [ROW_W-1:0]        emit_row;
  logic [ADDR_W-1:0]       addr;
  logic                    rd_valid;
  logic                    rd_active;
  logic signed [DATA_WIDTH-1:0] x_re;
  logic signed [DATA_WIDTH-1:0] x_im;

  logic                    in_acc;
  logic                    out_acc;
  logic                    emit_last;
  logic                    last_elem;
  logic                    mac_busy;
  logic                    mac_vld;
  acc_t                    mac_sum;
  acc_t                    tail_add;
  cell_ctrl_t              cell_ctrl;
  logic [2*DATA_WIDTH-1:0] rd_data;
  acc_t                    cell_val [MAX_OUT_LEN];

  // handshakes and effective lengths
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);
  assign cfg_ready = 1'b1;
  assign lx        = clamp_len(in_len, MAX_IN_LEN);
  assign ly        = clamp_len(out_len, MAX_OUT_LEN);
  assign emit_last = (32'(emit_row) + 32'd1 == 32'(ly));
  assign last_elem = (32'(count) + 32'd1 >= 32'(lx));

  // sequencer: config registers, element count, coefficient issue and result emission
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_len    <= LEN_W'(1);
      out_len   <= LEN_W'(1);
      count     <= '0;
      row       <= '0;
      emit_row  <= '0;
      rd_valid  <= 1'b0;
      rd_active <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IN_LENGTH:  in_len  <= cfg_data;
          REG_OUT_LENGTH: out_len <= cfg_data;
          default: ;
        endcase
      end
      rd_valid  <= (state == ST_RUN);
      rd_active <= (32'(row) < 32'(ly));
      case (state)
        ST_IDLE: begin
          if (in_acc && op == OP_VECTOR) begin
            x_re  <= in_real;
            x_im  <= in_imag;
            row   <= '0;
            addr  <= ADDR_W'(count);
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          addr <= addr + ADDR_W'(lx);
          row  <= row + ROW_W'(1);
          if (row == ROW_W'(MAX_OUT_LEN - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_valid && !mac_busy) begin
            if (last_elem) begin
              count    <= '0;
              emit_row <= '0;
              state    <= ST_EMIT;
            end else begin
              count <= count + CNT_W'(1);
              state <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            emit_row <= emit_row + ROW_W'(1);
            if (emit_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // coefficient store, {imag, real} per entry
  cmvt_coef_mem #(
    .DATA_W(2 * DATA_WIDTH)
  ) u_mem (
    .clk    (clk),
    .wr_en  (in_acc && op == OP_LOAD),
    .wr_addr(coef_index),
    .wr_data({in_imag, in_real}),
    .rd_en  (state == ST_RUN),
    .rd_addr(addr),
    .rd_data(rd_data)
  );

  // complex multiply of coefficient and held element
  cmvt_mac #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (rd_valid),
    .in_active(rd_active),
    .coef_re  (rd_data[DATA_WIDTH-1:0]),
    .coef_im  (rd_data[2*DATA_WIDTH-1:DATA_WIDTH]),
    .x_re     (x_re),
    .x_im     (x_im),
    .busy     (mac_busy),
    .sum_vld  (mac_vld),
    .sum      (mac_sum)
  );

  // ring control: rotate on each product and each delivered result
  assign tail_add        = mac_vld ? mac_sum : '0;
  assign cell_ctrl.shift = mac_vld || out_acc;
  assign cell_ctrl.clear = out_acc && emit_last;

  // accumulator ring, head cell holds the current row
  for (genvar i = 0; i < MAX_OUT_LEN; i++) begin : g_cell
    if (i == MAX_OUT_LEN - 1) begin : g_tail
      cmvt_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (cell_ctrl),
        .prev  (cell_val[0]),
        .addend(tail_add),
        .value (cell_val[i])
      );
    end else begin : g_body
      cmvt_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (cell_ctrl),
        .prev  (cell_val[i+1]),
        .addend('0),
        .value (cell_val[i])
      );
    end
  end

  // result fields come straight from the head cell
  assign out_row  = OUT_ROW_W'(emit_row);
  assign out_real = cell_val[0].re;
  assign out_imag = cell_val[0].im;
  assign is_last  = emit_last;

  // requests and results never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("request and result channels active together");

  // products only arrive while a vector element is in flight
  a_mac_in_run: assert property (@(posedge clk) disable iff (rst)
    mac_vld |-> (state == ST_RUN || state == ST_DRAIN))
    else $error("product outside element processing");

  // element count restarts before results go out
  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (count == '0))
    else $error("element count not cleared during emission");

  // the marked result ends the output vector
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_acc && is_last) |=> !out_valid)
    else $error("result after the last one");

endmodule

/* test/tb.sv */
// testbench for complex_matrix_vector_transform_unit: directed and random requests, with results
// checked against a built-in model of y = A'x on 40-bit complex accumulators
// depends on cmvt_pkg and the complex_matrix_vector_transform_unit rtl
module tb;
  import cmvt_pkg::*;

  localparam int DW            = 16;
  localparam int MAX_LEN       = 64;
  localparam int RANDOM_ITEMS  = 110;
  localparam int LOAD_BUDGET   = 128;
  localparam int SETTLE_CYCLES = 2 * MAX_LEN + 20;
  localparam int CYCLE_LIMIT   = 1_000_000;

  typedef struct packed {
    logic                 op;
    logic [ADDR_W-1:0]    index;
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
  } request_t;

  typedef struct packed {
    logic [OUT_ROW_W-1:0]    row;
    logic signed [ACC_W-1:0] re;
    logic signed [ACC_W-1:0] im;
    logic                    last;
  } row_result_t;

  logic                    clk        = 1'b0;
  logic                    rst        = 1'b1;
  logic                    in_valid   = 1'b0;
  logic                    in_ready;
  logic                    op         = OP_LOAD;
  logic [ADDR_W-1:0]       coef_index = '0;
  logic signed [DW-1:0]    in_real    = '0;
  logic signed [DW-1:0]    in_imag    = '0;
  logic                    out_valid;
  logic                    out_ready  = 1'b0;
  logic [OUT_ROW_W-1:0]    out_row;
  logic signed [ACC_W-1:0] out_real;
  logic signed [ACC_W-1:0] out_imag;
  logic                    is_last;
  logic                    cfg_valid  = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index  = REG_IN_LENGTH;
  logic [LEN_W-1:0]        cfg_data   = '0;

  // model state: coefficient store, row accumulators, element count, lengths
  logic signed [DW-1:0]    coef_re [STORE_DEPTH];
  logic signed [DW-1:0]    coef_im [STORE_DEPTH];
  logic signed [ACC_W-1:0] row_acc_re [MAX_LEN];
  logic signed [ACC_W-1:0] row_acc_im [MAX_LEN];
  int                      elems_seen;
  logic [LEN_W-1:0]        in_len_reg;
  logic [LEN_W-1:0]        out_len_reg;

  // stimulus side: store entries already queued for loading, element position of queued vectors
  bit          coef_loaded [STORE_DEPTH];
  int          elem_pos    = 0;

  request_t    req_q[$];
  row_result_t pending_rows[$];
  request_t    cur_req;
  int          reqs_pushed = 0;
  int          reqs_taken  = 0;
  int          mismatches  = 0;
  int          cycle_count = 0;

  complex_matrix_vector_transform_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .coef_index (coef_index),
    .in_real    (in_real),
    .in_imag    (in_imag),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_row    (out_row),
    .out_real   (out_real),
    .out_imag   (out_imag),
    .is_last    (is_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // zero reads as one, anything above the maximum as the maximum
  function automatic int eff_len(logic [LEN_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_LEN) return MAX_LEN;
    return int'(v);
  endfunction

  // apply one accepted request to the model and queue the rows it completes
  function automatic void transform_step(request_t req);
    int     lx;
    int     ly;
    int     a;
    longint pr;
    longint pi;
    if (req.op == OP_LOAD) begin
      coef_re[req.index] = req.re;
      coef_im[req.index] = req.im;
      return;
    end
    lx = eff_len(in_len_reg);
    ly = eff_len(out_len_reg);
    for (int r = 0; r < ly; r++) begin
      a  = (r * lx + elems_seen) % STORE_DEPTH;
      pr = longint'(coef_re[a]) * longint'(req.re) - longint'(coef_im[a]) * longint'(req.im);
      pi = longint'(coef_re[a]) * longint'(req.im) + longint'(coef_im[a]) * longint'(req.re);
      row_acc_re[r] = ACC_W'(row_acc_re[r] + pr);
      row_acc_im[r] = ACC_W'(row_acc_im[r] + pi);
    end
    elems_seen++;
    if (elems_seen < lx) return;
    for (int r = 0; r < ly; r++) begin
      pending_rows.push_back('{row: OUT_ROW_W'(r), re: row_acc_re[r], im: row_acc_im[r],
                               last: (r == ly - 1)});
    end
    for (int r = 0; r < MAX_LEN; r++) begin
      row_acc_re[r] = '0;
      row_acc_im[r] = '0;
    end
    elems_seen = 0;
  endfunction

  // sample value biased toward the extremes and zero
  function automatic logic signed [DW-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(DW-1){1'b0}}};
      1: return {1'b0, {(DW-1){1'b1}}};
      2: return '0;
      default: return DW'($urandom);
    endcase
  endfunction

  // length register value: mostly small, sometimes zero, the maximum or above it
  function automatic logic [LEN_W-1:0] random_length();
    case ($urandom_range(0, 11))
      0: return LEN_W'(MAX_LEN);
      1: return LEN_W'($urandom_range(MAX_LEN + 1, 127));
      2: return '0;
      3: return LEN_W'(1);
      default: return LEN_W'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic void push_request(logic req_op, logic [ADDR_W-1:0] idx,
                                       logic signed [DW-1:0] re, logic signed [DW-1:0] im);
    req_q.push_back('{op: req_op, index: idx, re: re, im: im});
    if (req_op == OP_LOAD) begin
      coef_loaded[idx] = 1'b1;
    end
    reqs_pushed++;
  endfunction

  // queue one vector element, first loading every coefficient it reads that was never loaded
  function automatic void push_vector(logic signed [DW-1:0] re, logic signed [DW-1:0] im);
    int lx;
    int ly;
    int a;
    lx = eff_len(in_len_reg);
    ly = eff_len(out_len_reg);
    for (int r = 0; r < ly; r++) begin
      a = (r * lx + elem_pos) % STORE_DEPTH;
      if (!coef_loaded[a]) begin
        push_request(OP_LOAD, ADDR_W'(a), rand_sample(), rand_sample());
      end
    end
    push_request(OP_VECTOR, ADDR_W'($urandom), re, im);
    elem_pos = (elem_pos + 1 >= lx) ? 0 : elem_pos + 1;
  endfunction

  function automatic void check_field(string name, logic [ACC_W-1:0] want_v,
                                      logic [ACC_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want_v, got_v);
      mismatches++;
    end
  endfunction

  // wait until every request is taken and every row is out, then let the block settle
  task automatic wait_idle();
    while (reqs_taken != reqs_pushed || pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both length registers back to back, valid held high across the two
  task automatic set_lengths(logic [LEN_W-1:0] in_len, logic [LEN_W-1:0] out_len);
    cfg_valid <= 1'b1;
    cfg_index <= REG_IN_LENGTH;
    cfg_data  <= in_len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    in_len_reg = in_len;
    cfg_index <= REG_OUT_LENGTH;
    cfg_data  <= out_len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    out_len_reg = out_len;
    cfg_valid <= 1'b0;
  endtask

  // request driver: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        transform_step(cur_req);
        reqs_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          op         <= cur_req.op;
          coef_index <= cur_req.index;
          in_real    <= cur_req.re;
          in_imag    <= cur_req.im;
          in_valid   <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: ready follows a rotating stall pattern, refreshed every lap
  logic [15:0] stall_pat = '1;
  int          pat_pos   = 0;
  always @(posedge clk) begin : receive
    row_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_rows.size() == 0) begin
          $display("%0t: unexpected result, expected none actual row %0d re %h im %h last %b",
                   $time, out_row, out_real, out_imag, is_last);
          mismatches++;
        end else begin
          want = pending_rows.pop_front();
          check_field("out_row", ACC_W'(want.row), ACC_W'(out_row));
          check_field("out_real", want.re, out_real);
          check_field("out_imag", want.im, out_imag);
          check_field("is_last", ACC_W'(want.last), ACC_W'(is_last));
        end
      end
      pat_pos = (pat_pos + 1) % 16;
      if (pat_pos == 0) begin
        stall_pat = ($urandom_range(0, 2) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
      end
      out_ready <= stall_pat[pat_pos];
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[complex_matrix_vector_transform_unit] ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    int               lx;
    int               n_vec;
    int               n_elem;
    int               start_count;
    int               phase;
    bit               broken;
    logic [LEN_W-1:0] lx_w;
    logic [LEN_W-1:0] ly_w;
    for (int r = 0; r < MAX_LEN; r++) begin
      row_acc_re[r] = '0;
      row_acc_im[r] = '0;
    end
    elems_seen  = 0;
    in_len_reg  = LEN_W'(1);
    out_len_reg = LEN_W'(1);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // most negative times most negative, then most positive values, at reset lengths
    push_request(OP_LOAD, '0, {1'b1, {(DW-1){1'b0}}}, {1'b1, {(DW-1){1'b0}}});
    push_vector({1'b1, {(DW-1){1'b0}}}, {1'b1, {(DW-1){1'b0}}});
    push_request(OP_LOAD, '0, {1'b0, {(DW-1){1'b1}}}, {1'b1, {(DW-1){1'b0}}});
    push_vector({1'b0, {(DW-1){1'b1}}}, {1'b0, {(DW-1){1'b1}}});
    push_request(OP_LOAD, '1, {1'b0, {(DW-1){1'b1}}}, {1'b0, {(DW-1){1'b1}}});
    push_vector('0, '0);
    push_vector({1'b1, {(DW-1){1'b0}}}, {1'b0, {(DW-1){1'b1}}});
    wait_idle();

    // zero input length acts as one, output length above the maximum acts as the maximum
    set_lengths('0, 7'd127);
    push_vector({1'b0, {(DW-1){1'b1}}}, {1'b1, {(DW-1){1'b0}}});
    wait_idle();

    // load in the middle of a vector, then shorter lengths before the vector ends
    set_lengths(7'd3, 7'd4);
    push_vector(rand_sample(), rand_sample());
    push_request(OP_LOAD, ADDR_W'(5), rand_sample(), rand_sample());
    push_vector(rand_sample(), rand_sample());
    wait_idle();
    set_lengths(7'd2, 7'd2);
    push_vector(rand_sample(), rand_sample());
    wait_idle();

    // random phases: the longest input vector first, then random lengths kept within a
    // small coefficient footprint, loads mixed in, sometimes cut short
    start_count = reqs_pushed;
    phase = 0;
    while (reqs_pushed - start_count < RANDOM_ITEMS) begin
      if (phase == 0) begin
        lx_w = LEN_W'(MAX_LEN);
        ly_w = LEN_W'(1);
      end else begin
        lx_w = random_length();
        ly_w = random_length();
        if (eff_len(lx_w) * eff_len(ly_w) > LOAD_BUDGET) begin
          ly_w = LEN_W'(LOAD_BUDGET / eff_len(lx_w));
        end
      end
      set_lengths(lx_w, ly_w);
      lx     = eff_len(lx_w);
      n_vec  = (lx == MAX_LEN) ? 1 : $urandom_range(1, 3);
      broken = ($urandom_range(0, 5) == 0);
      for (int v = 0; v < n_vec; v++) begin
        n_elem = (broken && v == n_vec - 1) ? $urandom_range(0, lx - 1) : lx;
        for (int e = 0; e < n_elem; e++) begin
          if ($urandom_range(0, 4) == 0) begin
            push_request(OP_LOAD, ADDR_W'($urandom), rand_sample(), rand_sample());
          end
          push_vector(rand_sample(), rand_sample());
        end
      end
      wait_idle();
      phase++;
    end

    wait_idle();
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("[complex_matrix_vector_transform_unit] OK");
    end else begin
      $display("[complex_matrix_vector_transform_unit] ERROR");
    end
    $finish;
  end

endmodule
